// ----- rtl/cht_pkg.sv -----
package cht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] key;
  } in_word_t;

  typedef struct packed {
    logic [3:0] position;
    logic       overflow;
  } out_word_t;

  localparam int unsigned KeyW = 31;
  localparam int unsigned CfgW = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic mod_start;  // clear the remainder and bit counter
    logic mod_step;   // one restoring-division step
    logic len_rd;     // register the chain length of the bucket
    logic slot_rd;    // issue a memory read at the slot pointer
    logic slot_cmp;   // compare read data against the key
    logic ins_wr;     // shift-write one slot for an insert
    logic del_wr;     // shift-write one slot for a delete
    logic len_inc;
    logic len_dec;
    logic ptr_dec;
    logic ptr_inc;
    logic ptr_set_len;
    logic ptr_clr;
  } ctl_t;

  typedef struct packed {
    logic mod_done;
    logic full;
    logic ptr_at_end;   // slot pointer reached chain length
    logic ptr_zero;
    logic match;
    logic del_last;     // pointer + 1 reached chain length
  } sts_t;

endpackage

// ----- rtl/cht_datapath.sv -----
module cht_datapath
  import cht_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 64,
  parameter int unsigned CHAIN_DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  in_word_t        in_i,
  input  ctl_t            ctl_i,
  output sts_t            sts_o,
  output logic [1:0]      cmd_o,
  output logic [3:0]      pos_o
);

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int unsigned LW = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned MW = (CfgW > BW + 1) ? CfgW : BW + 1;
  localparam int unsigned CW = $clog2(KeyW + 1);

  logic [CfgW-1:0] cfg_q;
  logic [MW-1:0]   div_m;
  logic [MW-1:0]   rem_q, rem_d;
  logic [KeyW-1:0] key_q, shk_q;
  logic [1:0]      cmd_q;
  logic [CW-1:0]   bit_cnt_q;
  logic [LW-1:0]   len_q [NUM_BUCKETS];
  logic [LW-1:0]   cur_len_q;
  logic [LW-1:0]   ptr_q;
  logic [KeyW-1:0] mem_q [2**(BW+SW)];
  logic [KeyW-1:0] rd_q;
  logic [MW:0]     trial;
  logic [BW-1:0]   bucket;
  logic [BW+SW-1:0] rd_addr, wr_addr;
  logic [KeyW-1:0] wr_data;
  logic            wr_en;

  // Clamp the divisor to the range 1 .. NUM_BUCKETS.
  always_comb begin
    if (cfg_q == '0) begin
      div_m = MW'(1);
    end else if (MW'(cfg_q) > MW'(NUM_BUCKETS)) begin
      div_m = MW'(NUM_BUCKETS);
    end else begin
      div_m = MW'(cfg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(64);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign trial = {rem_q, shk_q[KeyW-1]} - {1'b0, div_m};
  assign rem_d = trial[MW] ? {rem_q[MW-2:0], shk_q[KeyW-1]} : trial[MW-1:0];
  assign bucket = rem_q[BW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= in_i.key;
      cmd_q <= in_i.cmd;
    end
    if (ctl_i.mod_start) begin
      shk_q <= key_q;
      rem_q <= '0;
    end else if (ctl_i.mod_step) begin
      shk_q <= {shk_q[KeyW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
    end else if (ctl_i.mod_start) begin
      bit_cnt_q <= '0;
    end else if (ctl_i.mod_step) begin
      bit_cnt_q <= bit_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) len_q[i] <= '0;
    end else if (ctl_i.len_inc) begin
      len_q[bucket] <= cur_len_q + LW'(1);
    end else if (ctl_i.len_dec) begin
      len_q[bucket] <= cur_len_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_rd) cur_len_q <= len_q[bucket];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (ctl_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (ctl_i.ptr_set_len) begin
      ptr_q <= cur_len_q;
    end else if (ctl_i.ptr_dec) begin
      ptr_q <= ptr_q - LW'(1);
    end else if (ctl_i.ptr_inc) begin
      ptr_q <= ptr_q + LW'(1);
    end
  end

  // Insert reads slot ptr-1 and writes it to slot ptr; delete reads ptr+1
  // into ptr. The controller reads first, writes in the following cycle.
  always_comb begin
    rd_addr = {bucket, ptr_q[SW-1:0]};
    wr_addr = {bucket, ptr_q[SW-1:0]};
    wr_data = rd_q;
    wr_en   = ctl_i.ins_wr || ctl_i.del_wr;
    if (ctl_i.ins_wr && ptr_q == '0) wr_data = key_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (ctl_i.slot_rd) rd_q <= mem_q[rd_addr];
  end

  assign sts_o.mod_done   = (bit_cnt_q == CW'(KeyW));
  assign sts_o.full       = (cur_len_q >= LW'(CHAIN_DEPTH));
  assign sts_o.ptr_at_end = (ptr_q >= cur_len_q);
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.match      = ctl_i.slot_cmp && (rd_q == key_q);
  assign sts_o.del_last   = ((LW+1)'(ptr_q) + (LW+1)'(1) >= (LW+1)'(cur_len_q));
  assign cmd_o            = cmd_q;
  assign pos_o            = 4'((LW+1)'(ptr_q) + (LW+1)'(1));

endmodule

// ----- rtl/cht_ctrl.sv -----
module cht_ctrl
  import cht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sts_t       sts_i,
  input  logic [1:0] cmd_i,
  input  logic [3:0] pos_i,
  output ctl_t       ctl_o,
  output logic       done,
  output out_word_t  res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODST = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_DISP  = 4'd4;
  localparam logic [3:0] S_IRD   = 4'd5;
  localparam logic [3:0] S_IWR   = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SCMP  = 4'd8;
  localparam logic [3:0] S_DRD   = 4'd9;
  localparam logic [3:0] S_DWR   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_DMOV  = 4'd12;

  logic [3:0] state_q, state_d;
  out_word_t  res_q, res_d;
  logic       done_q, done_d;

  // An insert starts with the pointer at the chain length and walks it down:
  // each step steps back, reads the slot there, steps forward and writes the
  // read key one slot further on, then steps back again.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    done_d  = 1'b0;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_MODST;
        end
      end
      S_MODST: begin
        ctl_o.mod_start = 1'b1;
        state_d         = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          ctl_o.len_rd = 1'b1;
          state_d      = S_LEN;
        end else begin
          ctl_o.mod_step = 1'b1;
        end
      end
      S_LEN: begin
        res_d = '0;
        if (cmd_i == CMD_INSERT) begin
          if (sts_i.full) begin
            res_d.overflow = 1'b1;
            state_d        = S_FIN;
          end else begin
            ctl_o.ptr_set_len = 1'b1;
            state_d           = S_DISP;
          end
        end else if (cmd_i == CMD_SEARCH || cmd_i == CMD_DELETE) begin
          ctl_o.ptr_clr = 1'b1;
          state_d       = S_SRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DISP: begin
        // Insert: ptr is the slot to fill; read the slot before it.
        if (sts_i.ptr_zero) begin
          ctl_o.ins_wr  = 1'b1;
          ctl_o.len_inc = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.ptr_dec = 1'b1;
          state_d       = S_IRD;
        end
      end
      S_IRD: begin
        ctl_o.slot_rd = 1'b1;
        ctl_o.ptr_inc = 1'b1;
        state_d       = S_IWR;
      end
      S_IWR: begin
        ctl_o.ins_wr  = 1'b1;
        ctl_o.ptr_dec = 1'b1;
        state_d       = S_DISP;
      end
      S_SRD: begin
        if (sts_i.ptr_at_end) begin
          state_d = S_FIN;
        end else begin
          ctl_o.slot_rd = 1'b1;
          state_d       = S_SCMP;
        end
      end
      S_SCMP: begin
        ctl_o.slot_cmp = 1'b1;
        if (sts_i.match) begin
          res_d.position = pos_i;
          if (cmd_i == CMD_DELETE) begin
            state_d = S_DRD;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          ctl_o.ptr_inc = 1'b1;
          state_d       = S_SRD;
        end
      end
      S_DRD: begin
        // Close the gap: slot ptr takes slot ptr+1 until the chain end.
        if (sts_i.del_last) begin
          ctl_o.len_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.ptr_inc = 1'b1;
          state_d       = S_DWR;
        end
      end
      S_DWR: begin
        ctl_o.slot_rd = 1'b1;
        ctl_o.ptr_dec = 1'b1;
        state_d       = S_DMOV;
      end
      S_DMOV: begin
        ctl_o.del_wr  = 1'b1;
        ctl_o.ptr_inc = 1'b1;
        state_d       = S_DRD;
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy  = (state_q != S_IDLE);
  assign done  = done_q;
  assign res_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result strobe outside idle");
  a_ovf_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.overflow |-> res_q.position == 4'd0)
    else $error("overflow with a position");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == S_MODST) else $error("word not taken");

endmodule

// ----- rtl/chained_hash_table.sv -----
// Separate-chaining hash table: each word is an insert, search or delete of one
// key, hashed to bucket key mod bucket_count. The block takes a word when start
// is high and busy low, and gives one result word with a one-cycle done strobe,
// which the receiver must take. A word passes through setup, a bit-serial
// modulo by restoring division and a chain length read; then a search compares
// slot by slot, an insert shifts the chain up one slot from its end, and a
// delete compares and then closes the gap through the key memory, reading and
// writing one slot per move; a finish state follows. The done strobe comes in
// the first idle cycle, in which the next word may already be taken. The
// bucket count may change only while busy is low; stored keys are not rehashed.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 64,
  parameter int unsigned CHAIN_DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            start,
  output logic            busy,
  input  in_word_t        in_i,
  output logic            done,
  output out_word_t       out_o
);

  ctl_t       ctl;
  sts_t       sts;
  logic [1:0] cmd;
  logic [3:0] pos;

  cht_datapath #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i,
    .ctl_i(ctl), .sts_o(sts), .cmd_o(cmd), .pos_o(pos)
  );

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy,
    .sts_i(sts), .cmd_i(cmd), .pos_i(pos),
    .ctl_o(ctl), .done, .res_o(out_o)
  );

endmodule
